// ===== design/lpfc_pkg.sv =====
// package: mode codes and conversion functions for the low precision float converter
package lpfc_pkg;

   typedef enum logic [2:0] {
      MODE_F32_BF16  = 3'd0,
      MODE_BF16_F32  = 3'd1,
      MODE_F32_E4M3  = 3'd2,
      MODE_E4M3_F32  = 3'd3,
      MODE_F32_E5M2  = 3'd4,
      MODE_E5M2_F32  = 3'd5,
      MODE_F32_E2M1  = 3'd6,
      MODE_E2M1_F32  = 3'd7
   } mode_type;

   localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
   localparam logic [31:0] INF32  = 32'h7F80_0000;
   localparam logic [6:0]  E4M3_SAT = 7'h7E;
   localparam logic [6:0]  E5M2_SAT = 7'h7C;

   localparam logic [30:0] THR_5P0  = 31'h40A0_0000;
   localparam logic [30:0] THR_3P5  = 31'h4060_0000;
   localparam logic [30:0] THR_2P5  = 31'h4020_0000;
   localparam logic [30:0] THR_1P75 = 31'h3FE0_0000;
   localparam logic [30:0] THR_1P25 = 31'h3FA0_0000;
   localparam logic [30:0] THR_0P75 = 31'h3F40_0000;
   localparam logic [30:0] THR_0P25 = 31'h3E80_0000;

   function automatic logic [15:0] to_bf16(input logic [31:0] w);
      logic [31:0] sum;
      begin
         sum = w + 32'h0000_7FFF + {31'd0, w[16]};
         if (w[30:23] == 8'hFF)
            to_bf16 = {w[31], 15'h7F80 | {8'd0, (w[22:0] != 23'd0), 6'd0}};
         else if (w[30:23] == 8'd0 && w[22:16] == 7'd0)
            to_bf16 = {w[31], 15'd0};
         else
            to_bf16 = sum[31:16];
      end
   endfunction

   // e4m3 when is_e4m3, else e5m2; truncating
   function automatic logic [7:0] to_fp8(input logic [31:0] w, input logic is_e4m3);
      logic [9:0]  e;
      logic [8:0]  sh;
      logic [23:0] shifted;
      logic [2:0]  k;
      logic [6:0]  res;
      begin
         if (is_e4m3) e = {2'd0, w[30:23]} - 10'd120;
         else         e = {2'd0, w[30:23]} - 10'd112;
         // subnormal shift: (1-e) + 23 - mb
         sh = is_e4m3 ? 9'(10'd21 - e) : 9'(10'd22 - e);
         shifted = (sh > 9'd23) ? 24'd0 : ({1'b1, w[22:0]} >> sh[4:0]);
         res = 7'd0;
         if (w[30:0] == 31'd0)
            res = 7'd0;
         else if (w[30:23] == 8'hFF)
            res = (w[22:0] != 23'd0) ? 7'h7F : (is_e4m3 ? E4M3_SAT : E5M2_SAT);
         else if (e[9] || e == 10'd0) begin
            if (sh > 9'd23) res = 7'd0;
            else res = is_e4m3 ? {4'd0, shifted[2:0]} : {5'd0, shifted[1:0]};
         end else if (is_e4m3) begin
            k = w[22:20];
            if (e > 10'd15) res = E4M3_SAT;
            else if (e == 10'd15 && k == 3'd7) res = {4'd15, 3'd6};
            else res = {e[3:0], k};
         end else begin
            if (e >= 10'd31) res = E5M2_SAT;
            else res = {e[4:0], w[22:21]};
         end
         to_fp8 = {w[31], res};
      end
   endfunction

   function automatic logic [31:0] sub_to_f32(input logic s, input logic [2:0] m,
                                              input logic [7:0] base);
      begin
         if (m[2])      sub_to_f32 = {s, 8'(base + 8'd2), m[1:0], 21'd0};
         else if (m[1]) sub_to_f32 = {s, 8'(base + 8'd1), m[0], 22'd0};
         else           sub_to_f32 = {s, base, 23'd0};
      end
   endfunction

   function automatic logic [31:0] from_e4m3(input logic [7:0] c);
      begin
         if (c[6:3] == 4'd0)
            from_e4m3 = (c[2:0] != 3'd0) ? sub_to_f32(c[7], c[2:0], 8'd118)
                                         : {c[7], 31'd0};
         else if (c[6:0] == 7'h7F)
            from_e4m3 = {c[7], QNAN32[30:0]};
         else
            from_e4m3 = {c[7], 8'({4'd0, c[6:3]} + 8'd120), c[2:0], 20'd0};
      end
   endfunction

   function automatic logic [31:0] from_e5m2(input logic [7:0] c);
      begin
         if (c[6:2] == 5'd0)
            from_e5m2 = (c[1:0] != 2'd0) ? sub_to_f32(c[7], {1'b0, c[1:0]}, 8'd111)
                                         : {c[7], 31'd0};
         else if (c[6:2] == 5'd31)
            from_e5m2 = {c[7], (c[1:0] != 2'd0) ? QNAN32[30:0] : INF32[30:0]};
         else
            from_e5m2 = {c[7], 8'({3'd0, c[6:2]} + 8'd112), c[1:0], 21'd0};
      end
   endfunction

   function automatic logic [3:0] to_e2m1(input logic [31:0] w);
      logic [30:0] a;
      logic [2:0]  c;
      begin
         a = w[30:0];
         if (a == 31'd0)                  c = 3'd0;
         else if (w[30:23] == 8'hFF)      c = (w[22:0] != 23'd0) ? 3'd7 : 3'd6;
         else if (a >= THR_5P0)           c = 3'd7;
         else if (a >= THR_3P5)           c = 3'd6;
         else if (a >= THR_2P5)           c = 3'd5;
         else if (a >= THR_1P75)          c = 3'd4;
         else if (a >= THR_1P25)          c = 3'd3;
         else if (a >= THR_0P75)          c = 3'd2;
         else if (a >= THR_0P25)          c = 3'd1;
         else                             c = 3'd0;
         to_e2m1 = {w[31], c};
      end
   endfunction

   function automatic logic [31:0] from_e2m1(input logic [3:0] c);
      begin
         if (c[2:1] == 2'd0)
            from_e2m1 = c[0] ? {c[3], 31'h3F00_0000} : {c[3], 31'd0};
         else
            from_e2m1 = {c[3], 8'({6'd0, c[2:1]} + 8'd126), c[0], 22'd0};
      end
   endfunction

endpackage

// ===== design/lpfc_convert.sv =====
// combinational conversion datapath selected by mode
module lpfc_convert (
   input  logic [2:0]  mode,
   input  logic [31:0] source_word,
   output logic [31:0] converted_word
);
   always_comb begin
      case (lpfc_pkg::mode_type'(mode))
         lpfc_pkg::MODE_F32_BF16: converted_word = {16'd0, lpfc_pkg::to_bf16(source_word)};
         lpfc_pkg::MODE_BF16_F32: converted_word = {source_word[15:0], 16'd0};
         lpfc_pkg::MODE_F32_E4M3: converted_word = {24'd0, lpfc_pkg::to_fp8(source_word, 1'b1)};
         lpfc_pkg::MODE_E4M3_F32: converted_word = lpfc_pkg::from_e4m3(source_word[7:0]);
         lpfc_pkg::MODE_F32_E5M2: converted_word = {24'd0, lpfc_pkg::to_fp8(source_word, 1'b0)};
         lpfc_pkg::MODE_E5M2_F32: converted_word = lpfc_pkg::from_e5m2(source_word[7:0]);
         lpfc_pkg::MODE_F32_E2M1: converted_word = {28'd0, lpfc_pkg::to_e2m1(source_word)};
         lpfc_pkg::MODE_E2M1_F32: converted_word = lpfc_pkg::from_e2m1(source_word[3:0]);
         default:                 converted_word = 32'd0;
      endcase
   end
endmodule

// ===== design/low_precision_float_converter.sv =====
// top level: input register, conversion logic, result register
//  channel | ports                               | direction
//  req     | req_valid req_ready req_mode req_source_word | in
//  rsp     | rsp_valid rsp_ready rsp_converted_word       | out
// one beat per cycle while rsp is not stalled; a beat passes the input register, then the result register
// the input stage and result stage each hold one beat
// req_ready drops only when both stages are full and rsp is stalled
// synchronous active-high reset clears the valid flags
module low_precision_float_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [31:0] req_source_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_converted_word
);
   logic        in_vld_ff, in_vld_in;
   logic [2:0]  mode_ff;
   logic [31:0] word_ff;
   logic        out_vld_ff, out_vld_in;
   logic [31:0] res_ff;
   logic [31:0] res_in;
   logic        adv;

   lpfc_convert u_conv (
      .mode           (mode_ff),
      .source_word    (word_ff),
      .converted_word (res_in)
   );

   assign adv       = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || adv;
   assign in_vld_in = (req_valid && req_ready) || (in_vld_ff && !adv);
   assign out_vld_in = adv || (out_vld_ff && !rsp_ready);
   assign rsp_valid = out_vld_ff;
   assign rsp_converted_word = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff <= req_mode;
         word_ff <= req_source_word;
      end
      if (adv) res_ff <= res_in;
   end
endmodule
